// ===== sv/csp_pkg.sv =====
`timescale 1ns / 1ps

package csp_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int MAX_BASES   = 32;
  localparam int STRAND_W    = 64;
  localparam int LEN_W       = 6;
  localparam int COUNT_W     = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Search token walking the cell row, one cell per cycle
  typedef struct packed {
    logic                valid;
    logic [STRAND_W-1:0] bases;
    logic [STRAND_W-1:0] mask;
    logic [LEN_W-1:0]    len;
    logic                usable;
    logic                matched;
    logic                placed;
  } tok_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic clear;
    logic commit;
    logic cancel;
  } ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_WAIT
  } st_t;

  function automatic logic [STRAND_W-1:0] length_mask(input logic [LEN_W-1:0] len);
    logic [STRAND_W-1:0] m;
    m = '0;
    for (int b = 0; b < MAX_BASES; b++) begin
      if (LEN_W'(b) < len) begin
        m[2*b +: 2] = 2'b11;
      end
    end
    return m;
  endfunction

  function automatic logic strand_usable(input logic [LEN_W-1:0] len, input logic valid);
    return valid && (len != '0) && (len <= LEN_W'(MAX_BASES));
  endfunction

endpackage

// ===== sv/csp_ifs.sv =====
`timescale 1ns / 1ps

interface csp_in_if;
  import csp_pkg::*;

  logic                valid;
  logic                ready;
  logic                first_of_case;
  logic [STRAND_W-1:0] strand_bases;
  logic [LEN_W-1:0]    strand_length;
  logic                bases_valid;

  modport source (
    output valid, first_of_case, strand_bases, strand_length, bases_valid,
    input  ready
  );
  modport sink (
    input  valid, first_of_case, strand_bases, strand_length, bases_valid,
    output ready
  );
endinterface

interface csp_out_if;
  import csp_pkg::*;

  logic               valid;
  logic               ready;
  logic               paired;
  logic [COUNT_W-1:0] pair_count;
  logic               overflow;

  modport source (
    output valid, paired, pair_count, overflow,
    input  ready
  );
  modport sink (
    input  valid, paired, pair_count, overflow,
    output ready
  );
endinterface

// ===== sv/csp_cell.sv =====
`timescale 1ns / 1ps

module csp_cell (
  input  logic          clk,
  input  logic          rst,
  input  csp_pkg::ctl_t ctl,
  input  csp_pkg::tok_t tok_in,
  output csp_pkg::tok_t tok_out
);
  import csp_pkg::*;

  logic                occupied;
  logic                pending;
  logic [STRAND_W-1:0] strand;
  logic [LEN_W-1:0]    length;
  logic                usable;

  logic hit;
  logic take;
  tok_t tok_next;

  always_comb begin
    hit = tok_in.valid && tok_in.usable && !tok_in.matched && occupied && usable &&
          (length == tok_in.len) && (((strand ^ tok_in.bases) & tok_in.mask) == tok_in.mask);
    take = tok_in.valid && !tok_in.matched && !tok_in.placed && !occupied && !pending;
    tok_next         = tok_in;
    tok_next.matched = tok_in.matched | hit;
    tok_next.placed  = tok_in.placed | take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= 1'b0;
      pending  <= 1'b0;
      tok_out  <= '0;
    end else begin
      tok_out <= tok_next;
      if (ctl.clear || hit) begin
        occupied <= 1'b0;
      end else if (pending && ctl.commit) begin
        occupied <= 1'b1;
      end
      if (take) begin
        pending <= 1'b1;
      end else if (ctl.commit || ctl.cancel) begin
        pending <= 1'b0;
      end
    end
  end

  // Tentative write: kept only if the token reaches the end unmatched
  always_ff @(posedge clk) begin
    if (take) begin
      strand <= tok_in.bases;
      length <= tok_in.len;
      usable <= tok_in.usable;
    end
  end

endmodule

// ===== sv/complement_strand_pairing_table.sv =====
`timescale 1ns / 1ps
// An accepted strand enters the head token, which walks the row of entry cells one cell
//   per cycle; no new strand is taken until its result is loaded into the output register.
// Reset (synchronous, active high): empties every entry and zeroes the pair counter at once;
//   no clearing pass, the first strand may be taken in the cycle after reset.

module complement_strand_pairing_table (
  input logic       clk,
  input logic       rst,
  csp_in_if.sink    strand,
  csp_out_if.source result
);
  import csp_pkg::*;

  // Controller state
  st_t state;
  st_t state_next;

  // Token injected at the head of the row, held for exactly one cycle
  tok_t head;
  tok_t chain_tok [TABLE_DEPTH+1];
  ctl_t ctl;

  logic [COUNT_W-1:0] pairs_formed;
  logic               res_paired;
  logic               res_overflow;

  logic               out_valid;
  logic               out_paired;
  logic [COUNT_W-1:0] out_count;
  logic               out_overflow;

  logic accept;
  logic finish;
  logic load;
  tok_t tail;

  assign tail = chain_tok[TABLE_DEPTH];
  assign chain_tok[0] = head;

  // Row of entry cells: each cell holds one table entry and passes the token on
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    csp_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .tok_in  (chain_tok[i]),
      .tok_out (chain_tok[i+1])
    );
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (strand.valid) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (tail.valid) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (!out_valid || result.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    strand.ready = 1'b0;
    finish       = 1'b0;
    load         = 1'b0;
    case (state)
      ST_IDLE:   strand.ready = 1'b1;
      ST_SEARCH: finish       = tail.valid;
      ST_WAIT:   load         = !out_valid || result.ready;
      default: begin
        strand.ready = 1'b0;
      end
    endcase
    accept     = strand.valid && strand.ready;
    // Clear ahead of the search: the token reaches cell 0 only in the following cycle
    ctl.clear  = accept && strand.first_of_case;
    // Settle the tentative write once the token has seen every entry
    ctl.commit = finish && tail.placed && !tail.matched;
    ctl.cancel = finish && tail.placed && tail.matched;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      head         <= '0;
      pairs_formed <= '0;
      out_valid    <= 1'b0;
    end else begin
      state      <= state_next;
      head.valid <= accept;
      if (accept) begin
        head.bases   <= strand.strand_bases;
        head.mask    <= length_mask(strand.strand_length);
        head.len     <= strand.strand_length;
        head.usable  <= strand_usable(strand.strand_length, strand.bases_valid);
        head.matched <= 1'b0;
        head.placed  <= 1'b0;
      end
      if (ctl.clear) begin
        pairs_formed <= '0;
      end else if (finish && tail.matched && (pairs_formed != COUNT_MAX)) begin
        pairs_formed <= pairs_formed + COUNT_W'(1);
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: hold until the transaction completes
  always_ff @(posedge clk) begin
    if (finish) begin
      res_paired   <= tail.matched;
      res_overflow <= !tail.matched && !tail.placed;
    end
    if (load) begin
      out_paired   <= res_paired;
      out_count    <= pairs_formed;
      out_overflow <= res_overflow;
    end
  end

  assign result.valid      = out_valid;
  assign result.paired     = out_paired;
  assign result.pair_count = out_count;
  assign result.overflow   = out_overflow;

endmodule

// ===== sim/tb_complement_strand_pairing_table.sv =====
`timescale 1ns / 1ps

module tb_complement_strand_pairing_table;
  import csp_pkg::*;

  localparam int RANDOM_ITEMS = 1350;
  localparam int LONG_HOLD    = 500;  // cycles the receiver holds off once
  localparam int HOLD_AT      = 400;  // results seen before the long hold starts

  // One strand as offered to the block, with the idle cycles to insert after it
  typedef struct {
    logic                first;
    logic [STRAND_W-1:0] bases;
    logic [LEN_W-1:0]    len;
    logic                ok;
    int unsigned         gap;
  } strand_item_t;

  typedef struct packed {
    logic               paired;
    logic [COUNT_W-1:0] count;
    logic               overflow;
  } pairing_result_t;

  logic clk;
  logic rst;

  csp_in_if  strand_bus ();
  csp_out_if result_bus ();

  complement_strand_pairing_table uut (
    .clk    (clk),
    .rst    (rst),
    .strand (strand_bus),
    .result (result_bus)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Strands still to be offered, and pairing results still to arrive
  strand_item_t    pending_strands[$];
  pairing_result_t awaited_results[$];

  // Shadow of the unpaired-strand table and the pair counter
  logic [STRAND_W-1:0] held_bases [TABLE_DEPTH];
  logic [LEN_W-1:0]    held_len   [TABLE_DEPTH];
  logic                held_ok    [TABLE_DEPTH];
  bit                  held_used  [TABLE_DEPTH];
  logic [COUNT_W-1:0]  pair_tally;

  int unsigned mismatches;
  int unsigned results_seen;
  bit          strand_taken;   // a strand transaction completed at the last rising edge
  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned hold_left;
  bit          long_hold_done;

  function automatic logic [STRAND_W-1:0] span_mask(input logic [LEN_W-1:0] len);
    if (len >= MAX_BASES) begin
      return '1;
    end
    return (STRAND_W'(1) << (2 * len)) - STRAND_W'(1);
  endfunction

  function automatic logic [STRAND_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly back to back or short idles, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 60);
  endfunction

  task automatic queue_strand(input logic first, input logic [STRAND_W-1:0] bases,
                              input logic [LEN_W-1:0] len, input logic ok,
                              input int unsigned gap);
    strand_item_t s;
    s.first = first;
    s.bases = bases;
    s.len   = len;
    s.ok    = ok;
    s.gap   = gap;
    pending_strands.insert(pending_strands.size(), s);
  endtask

  // Work out the pairing outcome of one accepted strand and advance the shadow table.
  // A strand pairs only with an occupied, well-formed entry of the same length whose
  // bases are all complements of its own (base XOR 3); the lowest such entry goes.
  task automatic predict_pairing(input strand_item_t it);
    logic [STRAND_W-1:0] m;
    pairing_result_t     res;
    bit                  hit;
    int                  slot;
    if (it.first) begin
      foreach (held_used[i]) held_used[i] = 1'b0;
      pair_tally = '0;
    end
    hit = 1'b0;
    m   = span_mask(it.len);
    if (it.ok && it.len != '0 && it.len <= MAX_BASES) begin
      for (int i = 0; i < TABLE_DEPTH && !hit; i++) begin
        if (held_used[i] && held_ok[i] && held_len[i] == it.len &&
            ((held_bases[i] ^ it.bases) & m) == m) begin
          held_used[i] = 1'b0;
          hit = 1'b1;
        end
      end
    end
    res.paired   = hit;
    res.overflow = 1'b0;
    if (hit) begin
      // The counter sticks at its ceiling
      if (pair_tally != COUNT_MAX) begin
        pair_tally = pair_tally + 1'b1;
      end
    end else begin
      // Unmatched: take the lowest free entry, or drop the strand when none is left
      slot = -1;
      for (int i = 0; i < TABLE_DEPTH && slot < 0; i++) begin
        if (!held_used[i]) begin
          slot = i;
        end
      end
      if (slot >= 0) begin
        held_bases[slot] = it.bases;
        held_len[slot]   = it.len;
        held_ok[slot]    = it.ok;
        held_used[slot]  = 1'b1;
      end else begin
        res.overflow = 1'b1;
      end
    end
    res.count = pair_tally;
    awaited_results.insert(awaited_results.size(), res);
  endtask

  // Record strand transactions at the rising edge for the driver, which runs on the falling edge
  always @(posedge clk) begin
    strand_taken <= !rst && strand_bus.valid && strand_bus.ready;
  end

  // Strand driver: hold the offered strand until it is taken, then predict it,
  // insert its idle gap and move on to the next one.
  always @(negedge clk) begin : feed_strands
    strand_item_t cur;
    if (rst === 1'b0) begin
      if (strand_taken) begin
        cur = pending_strands.pop_front();
        predict_pairing(cur);
        send_gap = cur.gap;
      end
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        strand_bus.valid <= 1'b0;
      end else if (pending_strands.size() != 0) begin
        cur = pending_strands[0];
        strand_bus.valid         <= 1'b1;
        strand_bus.first_of_case <= cur.first;
        strand_bus.strand_bases  <= cur.bases;
        strand_bus.strand_length <= cur.len;
        strand_bus.bases_valid   <= cur.ok;
      end else begin
        strand_bus.valid <= 1'b0;
      end
    end
  end

  // Result sink: random stalls, calm stretches with ready held high, and one long
  // hold-off so that the block backs up and stops taking strands.
  always @(negedge clk) begin : pace_results
    if (rst === 1'b0) begin
      if (!long_hold_done && results_seen >= HOLD_AT) begin
        hold_left      = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        result_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
        result_bus.ready <= 1'b0;
      end else begin
        if ((results_seen / 150) % 3 == 0 || $urandom_range(0, 3) != 0) begin
          stall_left = 0;
        end else begin
          stall_left = pick_gap();
        end
        result_bus.ready <= (stall_left == 0);
      end
    end
  end

  // Compare each result transaction with the oldest outstanding prediction
  always @(posedge clk) begin : check_results
    pairing_result_t want;
    if (rst === 1'b0 && result_bus.valid && result_bus.ready) begin
      results_seen = results_seen + 1;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got paired=%0d count=%0d overflow=%0d",
                 $time, result_bus.paired, result_bus.pair_count, result_bus.overflow);
        mismatches = mismatches + 1;
      end else begin
        want = awaited_results.pop_front();
        if (result_bus.paired !== want.paired) begin
          $display("%0t: paired mismatch: expected %0d, got %0d",
                   $time, want.paired, result_bus.paired);
          mismatches = mismatches + 1;
        end
        if (result_bus.pair_count !== want.count) begin
          $display("%0t: pair_count mismatch: expected %0d, got %0d",
                   $time, want.count, result_bus.pair_count);
          mismatches = mismatches + 1;
        end
        if (result_bus.overflow !== want.overflow) begin
          $display("%0t: overflow mismatch: expected %0d, got %0d",
                   $time, want.overflow, result_bus.overflow);
          mismatches = mismatches + 1;
        end
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin : run_regression
    strand_item_t        pick;
    strand_item_t        kept[$];   // strands of the current case that may still be stored
    logic [STRAND_W-1:0] m;
    logic [STRAND_W-1:0] d;
    logic [LEN_W-1:0]    len;
    logic                first;
    int unsigned         gap;
    int                  made;
    int                  case_len;
    int                  idx;
    int                  r;
    int                  sel;
    bit                  calm_case;
    bit                  fill_case;

    rst                      = 1'b1;
    strand_bus.valid         = 1'b0;
    strand_bus.first_of_case = 1'b0;
    strand_bus.strand_bases  = '0;
    strand_bus.strand_length = '0;
    strand_bus.bases_valid   = 1'b0;
    result_bus.ready         = 1'b0;
    pair_tally               = '0;
    foreach (held_used[i]) held_used[i] = 1'b0;

    // Directed: shortest and longest strands, all-A against all-T
    queue_strand(1'b1, 64'h0, 6'd1, 1'b1, 0);
    queue_strand(1'b0, 64'h3, 6'd1, 1'b1, 0);
    queue_strand(1'b0, 64'h0, 6'd32, 1'b1, 0);
    queue_strand(1'b0, '1, 6'd32, 1'b1, 0);
    d = rand64();
    queue_strand(1'b0, d, 6'd32, 1'b1, 0);
    queue_strand(1'b0, ~d, 6'd32, 1'b1, 2);
    // Invalid bases never pair, whether stored or new
    queue_strand(1'b0, 64'h1B, 6'd3, 1'b0, 0);
    queue_strand(1'b0, 64'h24, 6'd3, 1'b1, 0);
    queue_strand(1'b0, 64'h1B, 6'd3, 1'b0, 0);
    queue_strand(1'b0, 64'h1B, 6'd3, 1'b1, 0);
    // Lengths of zero and beyond the maximum act as invalid strands
    queue_strand(1'b0, rand64(), 6'd0, 1'b1, 0);
    queue_strand(1'b0, rand64(), 6'd33, 1'b1, 0);
    queue_strand(1'b0, '1, 6'd63, 1'b1, 0);
    queue_strand(1'b0, 64'h0, 6'd63, 1'b0, 1);
    // Two identical entries: each complement takes one; bits above the length are ignored
    queue_strand(1'b0, 64'hABCD_0000_0000_00E4, 6'd4, 1'b1, 0);
    queue_strand(1'b0, 64'h0000_7700_0000_00E4, 6'd4, 1'b1, 0);
    queue_strand(1'b0, 64'h5555_0000_0000_001B, 6'd4, 1'b1, 0);
    queue_strand(1'b0, 64'h1234_0000_0000_011B, 6'd4, 1'b1, 0);
    // Lengths must agree
    queue_strand(1'b0, 64'h6, 6'd2, 1'b1, 0);
    queue_strand(1'b0, 64'h9, 6'd3, 1'b1, 0);
    queue_strand(1'b0, 64'h9, 6'd2, 1'b1, 0);
    // A new case forgets the table and the counter
    queue_strand(1'b0, 64'h2D, 6'd5, 1'b1, 0);
    queue_strand(1'b1, 64'h3D2, 6'd5, 1'b1, 0);
    queue_strand(1'b0, 64'h2D, 6'd5, 1'b1, 3);
    d = rand64();
    queue_strand(1'b0, d, 6'd31, 1'b1, 0);
    queue_strand(1'b0, d ^ span_mask(6'd31), 6'd31, 1'b1, 0);

    // Random: cases of well-formed traffic, mostly strands and their complements;
    // fill cases store far more than they pair so the table runs full and drops strands.
    made = 0;
    while (made < RANDOM_ITEMS) begin
      fill_case = ($urandom_range(0, 4) == 0);
      calm_case = ($urandom_range(0, 3) == 0);
      case_len  = fill_case ? $urandom_range(75, 120) : $urandom_range(5, 50);
      kept.delete();
      for (int k = 0; k < case_len; k++) begin
        first = (k == 0) || ($urandom_range(0, 199) == 0);
        if (first) begin
          kept.delete();
        end
        gap = calm_case ? 0 : pick_gap();
        r   = $urandom_range(0, 99);
        if (fill_case) begin
          r = (k < 80) ? ((r < 5) ? r : r + 40) : r;
        end
        if (r < 45 && kept.size() != 0) begin
          // Complement of an earlier strand, fresh junk above its length
          idx  = $urandom_range(0, kept.size() - 1);
          pick = kept[idx];
          kept.delete(idx);
          m = span_mask(pick.len);
          queue_strand(first, ((pick.bases ^ m) & m) | (rand64() & ~m), pick.len,
                       $urandom_range(0, 9) != 0, gap);
        end else if (r < 53 && kept.size() != 0) begin
          // Same content again
          pick = kept[$urandom_range(0, kept.size() - 1)];
          m = span_mask(pick.len);
          queue_strand(first, (pick.bases & m) | (rand64() & ~m), pick.len, pick.ok, gap);
          kept.insert(kept.size(), pending_strands[$]);
        end else if (r < 61) begin
          // Bad characters
          len = LEN_W'($urandom_range(1, MAX_BASES));
          queue_strand(first, rand64(), len, 1'b0, gap);
          kept.insert(kept.size(), pending_strands[$]);
        end else if (r < 65) begin
          // Bad length
          len = ($urandom_range(0, 3) == 0) ? LEN_W'(0)
                                            : LEN_W'($urandom_range(MAX_BASES + 1, 63));
          queue_strand(first, rand64(), len, 1'($urandom_range(0, 1)), gap);
        end else begin
          // Fresh strand; short ones also pair by chance
          sel = $urandom_range(0, 9);
          if (sel < 3) begin
            len = LEN_W'($urandom_range(1, 3));
          end else if (sel == 3) begin
            len = LEN_W'(MAX_BASES);
          end else begin
            len = LEN_W'($urandom_range(1, MAX_BASES));
          end
          queue_strand(first, rand64(), len, 1'b1, gap);
          kept.insert(kept.size(), pending_strands[$]);
        end
        made = made + 1;
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Drain: every strand taken and every result checked, then watch for strays
    while (pending_strands.size() != 0 || awaited_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (TABLE_DEPTH + 8) @(posedge clk);

    if (mismatches == 0) begin
      $display("complement_strand_pairing_table regression: pass");
    end else begin
      $display("complement_strand_pairing_table regression: fail");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run
  initial begin : watchdog
    #40_000_000;
    $display("complement_strand_pairing_table regression: fail");
    $finish;
  end

endmodule
